### sv/bcpe_pkg.sv
package bcpe_pkg;

    // configuration register indexes
    localparam int unsigned IDX_BITS = 3;
    localparam logic [IDX_BITS-1:0] REG_POINT0   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_POINT1   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_POINT2   = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_POINT3   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_SEGMENTS = 3'd4;

    // segment count and curve parameter widths
    localparam int unsigned SEG_BITS  = 10;
    localparam logic [SEG_BITS-1:0] SEG_RESET = 10'd150;
    localparam int unsigned T_BITS    = 17;   // t in 0..65536, q0.16
    localparam int unsigned REM_BITS  = SEG_BITS + 1;
    localparam int unsigned DIV_CELLS = T_BITS;

    // weight datapath widths
    localparam int unsigned SQ_BITS   = 2 * T_BITS;      // t^2, u^2
    localparam int unsigned X3_BITS   = T_BITS + 1;      // 3t, 3u
    localparam int unsigned CUBE_BITS = 49;              // q0.48 up to 1.0
    localparam int unsigned WRND_BITS = 32;              // bits dropped to q0.16

    // word moving along the divider row
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [REM_BITS-1:0] rem;
        logic [T_BITS-1:0]   quot;
    } bcpe_div_t;

    // rounded bernstein weights, q0.16
    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic [3:0][T_BITS-1:0] w;
    } bcpe_wgt_t;

endpackage

### sv/bcpe_div_cell.sv
module bcpe_div_cell
    import bcpe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SEG_BITS-1:0] seg,
    input  bcpe_div_t           in_word,
    output bcpe_div_t           out_word
);

    logic [REM_BITS:0]   trial;
    logic                ge;
    logic [REM_BITS-1:0] kept;
    bcpe_div_t           stage_reg;
    bcpe_div_t           stage_next;

    // one restoring step: trial subtract, keep or restore, shift for next bit
    always_comb
    begin
        trial = {1'b0, in_word.rem} - {2'b00, seg};
        ge    = !trial[REM_BITS];
        kept  = ge ? trial[REM_BITS-1:0] : in_word.rem;
        stage_next.valid = in_word.valid;
        stage_next.last  = in_word.last;
        stage_next.rem   = {kept[REM_BITS-2:0], 1'b0};
        stage_next.quot  = {in_word.quot[T_BITS-2:0], ge};
    end

    // cell register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_word = stage_reg;

endmodule

### sv/bcpe_weights.sv
module bcpe_weights
    import bcpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bcpe_div_t in_word,
    output bcpe_wgt_t out_word
);

    localparam logic [T_BITS-1:0] ONE_Q16 = T_BITS'(65536);
    localparam logic [CUBE_BITS-1:0] HALF_LSB = CUBE_BITS'(64'd1 << (WRND_BITS - 1));

    logic [T_BITS-1:0]  u_a;
    logic [2:0]         valid_reg;
    logic [2:0]         last_reg;
    logic [T_BITS-1:0]  t_a_reg, u_a_reg;
    logic [X3_BITS-1:0] t3x_a_reg, u3x_a_reg;
    logic [SQ_BITS-1:0] t2_a_reg, u2_a_reg;
    logic [3:0][CUBE_BITS-1:0] cube_b_reg;
    logic [3:0][T_BITS-1:0]    w_c_reg;
    logic [T_BITS+1:0]         w_sum;

    assign u_a = ONE_Q16 - in_word.quot;

    // valid and last travel with the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_word.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= {last_reg[1:0], in_word.last};
    end

    // stage a: squares and triples of t and 1-t
    always_ff @(posedge clk)
    begin
        t_a_reg   <= in_word.quot;
        u_a_reg   <= u_a;
        t3x_a_reg <= {1'b0, in_word.quot} + {in_word.quot, 1'b0};
        u3x_a_reg <= {1'b0, u_a} + {u_a, 1'b0};
        t2_a_reg  <= SQ_BITS'(in_word.quot) * SQ_BITS'(in_word.quot);
        u2_a_reg  <= SQ_BITS'(u_a) * SQ_BITS'(u_a);
    end

    // stage b: exact q0.48 cubic terms
    always_ff @(posedge clk)
    begin
        cube_b_reg[0] <= CUBE_BITS'(u2_a_reg) * CUBE_BITS'(u_a_reg);
        cube_b_reg[1] <= CUBE_BITS'(u2_a_reg) * CUBE_BITS'(t3x_a_reg);
        cube_b_reg[2] <= CUBE_BITS'(t2_a_reg) * CUBE_BITS'(u3x_a_reg);
        cube_b_reg[3] <= CUBE_BITS'(t2_a_reg) * CUBE_BITS'(t_a_reg);
    end

    // stage c: round half up to q0.16
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            w_c_reg[k] <= T_BITS'((cube_b_reg[k] + HALF_LSB) >> WRND_BITS);
        end
    end

    assign out_word.valid = valid_reg[2];
    assign out_word.last  = last_reg[2];
    assign out_word.w     = w_c_reg;

    assign w_sum = (T_BITS+2)'(w_c_reg[0]) + (T_BITS+2)'(w_c_reg[1])
                 + (T_BITS+2)'(w_c_reg[2]) + (T_BITS+2)'(w_c_reg[3]);

    // four roundings of half an lsb each keep the weights within two of one
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_word.valid |-> (w_sum >= (T_BITS+2)'(65534) && w_sum <= (T_BITS+2)'(65538)))
        else $error("bernstein weights do not sum to one");

endmodule

### sv/bcpe_combine.sv
module bcpe_combine
    import bcpe_pkg::*;
#(
    parameter int unsigned COORD_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  bcpe_wgt_t                         in_word,
    input  logic [3:0][3*COORD_BITS-1:0]      points,
    output logic                              out_valid,
    output logic                              out_last,
    output logic [2:0][COORD_BITS-1:0]        out_xyz
);

    localparam int unsigned PW = COORD_BITS + T_BITS + 1;
    localparam int unsigned SW = PW + 2;
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(32768);
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic                              valid_d_reg, valid_e_reg;
    logic                              last_d_reg, last_e_reg;
    logic signed [3:0][2:0][PW-1:0]    prod_d_reg;
    logic        [2:0][COORD_BITS-1:0] xyz_e_reg;
    logic signed [SW-1:0]              acc [3];
    logic signed [SW-1:0]              shifted [3];
    logic        [2:0][COORD_BITS-1:0] xyz_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
        end
        else
        begin
            valid_d_reg <= in_word.valid;
            valid_e_reg <= valid_d_reg;
        end
    end

    // stage d: weight times coordinate, twelve independent products
    for (genvar k = 0; k < 4; k++)
    begin : g_pt
        for (genvar c = 0; c < 3; c++)
        begin : g_co
            logic signed [PW-1:0] wgt_s;
            logic signed [PW-1:0] crd_s;
            assign wgt_s = PW'(signed'({1'b0, in_word.w[k]}));
            assign crd_s = PW'(signed'(points[k][c*COORD_BITS +: COORD_BITS]));
            always_ff @(posedge clk)
            begin
                prod_d_reg[k][c] <= wgt_s * crd_s;
            end
        end
    end

    // stage e: sum, round half up, saturate
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = SW'($signed(prod_d_reg[0][c])) + SW'($signed(prod_d_reg[1][c]))
                   + SW'($signed(prod_d_reg[2][c])) + SW'($signed(prod_d_reg[3][c]))
                   + ROUND_HALF;
            shifted[c] = acc[c] >>> 16;
            if (shifted[c] > SAT_HI)
            begin
                xyz_next[c] = SAT_HI[COORD_BITS-1:0];
            end
            else if (shifted[c] < SAT_LO)
            begin
                xyz_next[c] = SAT_LO[COORD_BITS-1:0];
            end
            else
            begin
                xyz_next[c] = shifted[c][COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_d_reg <= in_word.last;
        last_e_reg <= last_d_reg;
        xyz_e_reg  <= xyz_next;
    end

    assign out_valid = valid_e_reg;
    assign out_last  = last_e_reg;
    assign out_xyz   = xyz_e_reg;

    // a result leaves through the stage d and stage e registers after its weights arrive
    a_combine_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_word.valid, 2))
        else $error("combine result without weights");

endmodule

### sv/cubic_bezier_point_eval.sv
// Cubic Bezier point evaluator. A sample index is taken on any cycle with start
// high (busy is never raised, so one index per clock); 22 cycles after the edge
// that takes the index, the point x, y, z and is_last appear for exactly one cycle
// with result_valid high, and the receiver must take it then, at the 23rd edge.
// The latency is set by the divider forming t = index*65536/segments, a row of 17
// cells resolving one quotient bit each, plus one input stage, three weight stages
// and two combine stages. Control points and segments are written over the cfg
// channel, which is always ready; write it only while no sample is in flight.
// A segments value of zero acts as one.
module cubic_bezier_point_eval
    import bcpe_pkg::*;
#(
    parameter int unsigned COORD_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [SEG_BITS-1:0]      sample_index,
    output logic                     result_valid,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic signed [COORD_BITS-1:0] point_z,
    output logic                     is_last,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_BITS-1:0]      cfg_index,
    input  logic [3*COORD_BITS-1:0]  cfg_data
);

    localparam int unsigned LATENCY = 1 + DIV_CELLS + 3 + 2;

    logic [3:0][3*COORD_BITS-1:0] point_reg;
    logic [SEG_BITS-1:0]          segments_reg;
    logic                         accept;
    logic [SEG_BITS-1:0]          idx_sat;
    bcpe_div_t                    head_reg;
    bcpe_div_t                    div_chain [DIV_CELLS+1];
    bcpe_wgt_t                    wgt;
    logic [2:0][COORD_BITS-1:0]   xyz;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_reg    <= '0;
            segments_reg <= SEG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_POINT0:   point_reg[0] <= cfg_data;
                REG_POINT1:   point_reg[1] <= cfg_data;
                REG_POINT2:   point_reg[2] <= cfg_data;
                REG_POINT3:   point_reg[3] <= cfg_data;
                REG_SEGMENTS: segments_reg <= (cfg_data[SEG_BITS-1:0] == '0)
                                              ? SEG_BITS'(1) : cfg_data[SEG_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // input stage: saturate the index to the segment count
    assign idx_sat = (sample_index > segments_reg) ? segments_reg : sample_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else
        begin
            head_reg.valid <= accept;
            head_reg.last  <= (sample_index >= segments_reg);
            head_reg.rem   <= REM_BITS'(idx_sat);
            head_reg.quot  <= '0;
        end
    end

    // divider row, one quotient bit per cell, msb first
    assign div_chain[0] = head_reg;

    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_div
        bcpe_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .seg      (segments_reg),
            .in_word  (div_chain[i]),
            .out_word (div_chain[i+1])
        );
    end

    bcpe_weights u_weights (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (div_chain[DIV_CELLS]),
        .out_word (wgt)
    );

    bcpe_combine #(
        .COORD_BITS (COORD_BITS)
    ) u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (wgt),
        .points    (point_reg),
        .out_valid (result_valid),
        .out_last  (is_last),
        .out_xyz   (xyz)
    );

    assign point_x = xyz[0];
    assign point_y = xyz[1];
    assign point_z = xyz[2];

    // every result traces back to one accepted index that has passed through every stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, LATENCY))
        else $error("result without a matching accepted index");

endmodule

### sim/curve_point_check.sv
module curve_point_check
    import bcpe_pkg::*;
#(
    parameter int unsigned CW = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [SEG_BITS-1:0]   sample_index,
    input  logic                  result_valid,
    input  logic signed [CW-1:0]  point_x,
    input  logic signed [CW-1:0]  point_y,
    input  logic signed [CW-1:0]  point_z,
    input  logic                  is_last,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [IDX_BITS-1:0]   cfg_index,
    input  logic [3*CW-1:0]       cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    localparam longint unsigned ONE_Q16 = 64'd65536;
    localparam longint signed   OUT_MAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam longint signed   OUT_MIN = -OUT_MAX - 64'sd1;

    typedef struct {
        logic [SEG_BITS-1:0] index;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                last;
    } curve_point_t;

    // shadow copy of the control points and segment count
    logic [3*CW-1:0]     ctrl [4];
    logic [SEG_BITS-1:0] segs_cfg;

    curve_point_t pending_points [$];
    int           fail_cnt = 0;
    int           pending_cnt = 0;

    assign mismatches  = fail_cnt;
    assign outstanding = pending_cnt;

    task automatic report_mismatch(input string msg);
        fail_cnt++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic signed [CW-1:0] got,
                                 input logic signed [CW-1:0] want,
                                 input logic [SEG_BITS-1:0] index);
        if (got !== want)
            report_mismatch($sformatf("index %0d %s: got %0d, expected %0d",
                                      index, name, got, want));
    endtask

    // q0.48 weight rounded half up to q0.16
    function automatic longint signed round_weight(input longint unsigned w48);
        return longint'((w48 + (64'd1 << 31)) >> 32);
    endfunction

    // curve point for one index under the current settings
    function automatic curve_point_t bezier_point(input logic [SEG_BITS-1:0] raw);
        curve_point_t         r;
        longint unsigned      seg;
        longint unsigned      idx;
        longint unsigned      t;
        longint unsigned      u;
        longint signed        w [4];
        longint signed        acc;
        longint signed        v;
        logic signed [CW-1:0] cv;
        logic signed [CW-1:0] res [3];
        seg = 64'(segs_cfg);
        // zero segments behaves as one
        if (seg == 0)
            seg = 1;
        idx = 64'(raw);
        if (idx > seg)
            idx = seg;
        t = (idx * ONE_Q16) / seg;
        u = ONE_Q16 - t;
        w[0] = round_weight(u * u * u);
        w[1] = round_weight(64'd3 * t * u * u);
        w[2] = round_weight(64'd3 * t * t * u);
        w[3] = round_weight(t * t * t);
        for (int c = 0; c < 3; c++)
        begin
            acc = 0;
            for (int k = 0; k < 4; k++)
            begin
                cv = ctrl[k][c*CW +: CW];
                acc += w[k] * longint'(cv);
            end
            // round half up, then clamp since weights may not sum to one
            v = (acc + 64'sd32768) >>> 16;
            if (v > OUT_MAX)
                v = OUT_MAX;
            else if (v < OUT_MIN)
                v = OUT_MIN;
            res[c] = v[CW-1:0];
        end
        r.index = raw;
        r.x     = res[0];
        r.y     = res[1];
        r.z     = res[2];
        r.last  = (idx == seg);
        return r;
    endfunction

    // watch the three channels on every edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        curve_point_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                ctrl[k] = '0;
            segs_cfg = SEG_RESET;
            pending_points.delete();
            pending_cnt = 0;
        end
        else
        begin
            // result word against the oldest prediction
            if (result_valid)
            begin
                if (pending_points.size() == 0)
                begin
                    report_mismatch($sformatf("result (%0d,%0d,%0d) last=%0b with none expected",
                                              point_x, point_y, point_z, is_last));
                end
                else
                begin
                    want = pending_points.pop_front();
                    compare_field("x", point_x, want.x, want.index);
                    compare_field("y", point_y, want.y, want.index);
                    compare_field("z", point_z, want.z, want.index);
                    compare_field("is_last", CW'(is_last), CW'(want.last), want.index);
                end
            end
            // register write, unknown indexes dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POINT0:   ctrl[0] = cfg_data;
                    REG_POINT1:   ctrl[1] = cfg_data;
                    REG_POINT2:   ctrl[2] = cfg_data;
                    REG_POINT3:   ctrl[3] = cfg_data;
                    REG_SEGMENTS: segs_cfg = cfg_data[SEG_BITS-1:0];
                    default:      ;
                endcase
            end
            // accepted index word goes to the back of the queue
            if (start && !busy)
                pending_points = {pending_points, bezier_point(sample_index)};
            pending_cnt = pending_points.size();
        end
    end

endmodule

### sim/tb.sv
module tb;
    import bcpe_pkg::*;

    localparam int unsigned CW = 16;
    localparam int CMAX = (1 << (CW - 1)) - 1;
    localparam int CMIN = -CMAX - 1;
    localparam int IDX_MAX = (1 << SEG_BITS) - 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 105;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [SEG_BITS-1:0]   sample_index;
    logic                  result_valid;
    logic signed [CW-1:0]  point_x;
    logic signed [CW-1:0]  point_y;
    logic signed [CW-1:0]  point_z;
    logic                  is_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_BITS-1:0]   cfg_index;
    logic [3*CW-1:0]       cfg_data;
    int                    mismatches;
    int                    outstanding;

    bit idling = 1'b0;
    int quiet = 0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cubic_bezier_point_eval #(
        .COORD_BITS   (CW)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_index (sample_index),
        .result_valid (result_valid),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .is_last      (is_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    curve_point_check #(
        .CW           (CW)
    ) point_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_index (sample_index),
        .result_valid (result_valid),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .is_last      (is_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // stall watchdog: cycles in which no word moves on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [3*CW-1:0] pack3(input int x, input int y, input int z);
        return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
    endfunction

    // coordinate biased towards the range ends
    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0:       return CMAX;
            1:       return CMIN;
            2:       return 0;
            3:       return -1;
            default: return int'($urandom);
        endcase
    endfunction

    function automatic logic [3*CW-1:0] rand_point();
        if ($urandom_range(0, 2) == 0)
            return (3*CW)'({$urandom, $urandom});
        return pack3(rand_coord(), rand_coord(), rand_coord());
    endfunction

    function automatic int rand_segments();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return IDX_MAX;
            3:       return $urandom_range(2, 8);
            4, 5:    return $urandom_range(1, 64);
            default: return $urandom_range(1, IDX_MAX);
        endcase
    endfunction

    // mostly within the curve, some past the end
    function automatic logic [SEG_BITS-1:0] pick_index(input int seg);
        int s;
        s = (seg == 0) ? 1 : seg;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SEG_BITS'(s);
            2:       return SEG_BITS'(IDX_MAX);
            3, 4, 5: return SEG_BITS'($urandom_range(0, IDX_MAX));
            default: return SEG_BITS'($urandom_range(0, s));
        endcase
    endfunction

    // one index word, then perhaps an idle burst
    task automatic send_index(input logic [SEG_BITS-1:0] v);
        start <= 1'b1;
        sample_index <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            sample_index <= SEG_BITS'($urandom);
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [3*CW-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_curve(input logic [3*CW-1:0] p0, input logic [3*CW-1:0] p1,
                                 input logic [3*CW-1:0] p2, input logic [3*CW-1:0] p3,
                                 input logic [3*CW-1:0] seg);
        write_reg(REG_POINT0, p0);
        write_reg(REG_POINT1, p1);
        write_reg(REG_POINT2, p2);
        write_reg(REG_POINT3, p3);
        write_reg(REG_SEGMENTS, seg);
        cfg_valid <= 1'b0;
    endtask

    // wait until every index sent has come back
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                seg_now;
        int                w;
        logic [3*CW-1:0]   d;
        logic [3*CW-1:0]   top_pt;
        logic [3*CW-1:0]   low_pt;
        start <= 1'b0;
        sample_index <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_POINT0;
        cfg_data <= '0;
        rst_n <= 1'b0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: flat curve at the origin, 150 segments
        send_index(0);
        send_index(SEG_RESET);
        send_index(SEG_BITS'(IDX_MAX));

        // extreme control points over the widest segment count
        settle();
        program_curve(pack3(CMIN, CMAX, 0), pack3(CMAX, CMIN, -1),
                      pack3(CMIN, CMIN, CMAX), pack3(CMAX, CMAX, CMIN),
                      (3*CW)'(IDX_MAX));
        send_index(0);
        send_index(1);
        send_index(511);
        send_index(512);
        send_index(SEG_BITS'(IDX_MAX - 1));
        send_index(SEG_BITS'(IDX_MAX));

        // zero segments acts as one
        top_pt = pack3(CMAX, CMAX, CMAX);
        low_pt = pack3(CMIN, CMIN, CMIN);
        settle();
        program_curve(top_pt, top_pt, top_pt, top_pt, 0);
        send_index(0);
        send_index(1);
        send_index(SEG_BITS'(IDX_MAX));

        // weight rounding pushing past full scale
        settle();
        write_reg(REG_SEGMENTS, 3);
        cfg_valid <= 1'b0;
        send_index(0);
        send_index(1);
        send_index(2);
        send_index(3);

        settle();
        program_curve(low_pt, low_pt, low_pt, low_pt, 7);
        send_index(1);
        send_index(2);
        send_index(3);
        send_index(5);

        // high data bits and unknown indexes are dropped
        settle();
        d = (3*CW)'({$urandom, $urandom});
        d[SEG_BITS-1:0] = 5;
        write_reg(REG_SEGMENTS, d);
        write_reg(IDX_BITS'(REG_SEGMENTS + 1), (3*CW)'({$urandom, $urandom}));
        write_reg(IDX_BITS'((1 << IDX_BITS) - 1), (3*CW)'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
        send_index(4);
        send_index(5);
        send_index(6);
        seg_now = 5;

        // random phases, each under fresh settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            idling = (p < RANDOM_PHASES - 2) && (p != 3);
            for (int r = REG_POINT0; r <= REG_SEGMENTS; r++)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    if (r == REG_SEGMENTS)
                    begin
                        seg_now = rand_segments();
                        d = (3*CW)'({$urandom, $urandom});
                        d[SEG_BITS-1:0] = SEG_BITS'(seg_now);
                    end
                    else
                    begin
                        d = rand_point();
                    end
                    write_reg(r[IDX_BITS-1:0], d);
                end
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(IDX_BITS'($urandom_range(REG_SEGMENTS + 1, (1 << IDX_BITS) - 1)),
                          (3*CW)'({$urandom, $urandom}));
            cfg_valid <= 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_index(pick_index(seg_now));
        end

        // drain, then keep waiting for any stray word
        start <= 1'b0;
        @(posedge clk);
        for (w = 0; w < QUIET_LIMIT && outstanding != 0; w++)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### cubic_bezier_point_eval.f
sv/bcpe_pkg.sv
sv/bcpe_div_cell.sv
sv/bcpe_weights.sv
sv/bcpe_combine.sv
sv/cubic_bezier_point_eval.sv
sim/curve_point_check.sv
sim/tb.sv
